// ----- src/infix_expression_evaluator_defines.svh -----
// assertion macros for the infix expression evaluator
// used by the controller and the top level
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// implication checked on every clock unless reset is high
`define IEE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every clock, reset included
`define IEE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/iee_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and helper functions for the infix expression evaluator
// no dependencies
package iee_pkg;

   localparam int VALUE_STACK_DEPTH    = 16;
   localparam int OPERATOR_STACK_DEPTH = 16;
   localparam int VAL_PTR_W = $clog2(VALUE_STACK_DEPTH);
   localparam int OP_PTR_W  = $clog2(OPERATOR_STACK_DEPTH);
   localparam int VAL_CNT_W = $clog2(VALUE_STACK_DEPTH + 1);
   localparam int OP_CNT_W  = $clog2(OPERATOR_STACK_DEPTH + 1);

   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

   // operator codes
   localparam logic [2:0] OP_LPAREN = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_SUB    = 3'd2;
   localparam logic [2:0] OP_MUL    = 3'd3;
   localparam logic [2:0] OP_DIV    = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_DIVZERO   = 3'd1;
   localparam logic [2:0] ST_PAREN     = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;
   localparam logic [2:0] ST_UNDERFLOW = 3'd5;
   localparam logic [2:0] ST_BADCHAR   = 3'd6;

   // characters
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   // datapath commands
   localparam logic [3:0] CMD_NONE     = 4'd0;
   localparam logic [3:0] CMD_DIGIT    = 4'd1;  // accumulate a digit
   localparam logic [3:0] CMD_PUSH_NUM = 4'd2;  // push accumulator, clear it
   localparam logic [3:0] CMD_PUSH_OP  = 4'd3;  // push op code
   localparam logic [3:0] CMD_POP_OP   = 4'd4;  // drop top op
   localparam logic [3:0] CMD_LOAD_B   = 4'd5;  // pop value into operand b
   localparam logic [3:0] CMD_LOAD_A   = 4'd6;  // pop value into operand a
   localparam logic [3:0] CMD_ARITH    = 4'd7;  // start the arithmetic unit
   localparam logic [3:0] CMD_PUSH_RES = 4'd8;  // push arithmetic result
   localparam logic [3:0] CMD_CLEAR    = 4'd9;  // clear counts and number
   localparam logic [3:0] CMD_READ_TOP = 4'd10; // no datapath action; the top value is always on status

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] arg;     // operator code
      logic [3:0] digit;
   } dp_cmd_type;

   typedef struct packed {
      logic [VAL_CNT_W-1:0] value_count;
      logic [OP_CNT_W-1:0]  operator_count;
      logic [2:0]           top_op;
      logic                 busy;        // arithmetic unit working
      logic                 b_zero;
      logic [63:0]          top_value;
   } dp_status_type;

   function automatic logic [1:0] prio(input logic [2:0] op);
      logic [1:0] p;
      p = 2'd0;
      if (op == OP_ADD || op == OP_SUB) p = 2'd1;
      if (op == OP_MUL || op == OP_DIV) p = 2'd2;
      return p;
   endfunction

   function automatic logic [63:0] signed_sat(input logic [63:0] mag, input logic neg,
                                              input logic ovf);
      logic [63:0] r;
      if (neg) r = (ovf || mag > SMIN) ? SMIN : (64'd0 - mag);
      else     r = (ovf || mag > SMAX) ? SMAX : mag;
      return r;
   endfunction

endpackage

// ----- src/iee_arith.sv -----
`timescale 1ns / 1ps
// iterative saturating arithmetic unit: add, subtract, shift-add multiply
// and restoring divide on q31.32 values; uses iee_pkg
module iee_arith
   import iee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  op,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        busy,
   output logic [63:0] result
);

   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [2:0]  op_ff, op_in;
   logic        neg_ff, neg_in;
   logic [63:0] ua_ff, ua_in;    // multiplier / dividend shift register
   logic [63:0] ub_ff, ub_in;
   logic [127:0] acc_ff, acc_in; // product, or divider quotient
   logic [64:0] rem_ff, rem_in;
   logic        ovf_ff, ovf_in;
   logic [63:0] res_ff, res_in;

   logic [63:0] ma, mb, sum, dif;
   logic [64:0] rsh, rsub;
   logic        dbit;

   always_comb begin
      ma  = a[63] ? (64'd0 - a) : a;
      mb  = b[63] ? (64'd0 - b) : b;
      sum = a + b;
      dif = a - b;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      neg_in  = neg_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      ovf_in  = ovf_ff;
      res_in  = res_ff;
      dbit    = 1'b0;
      rsh     = '0;
      rsub    = '0;
      if (start) begin
         op_in  = op;
         neg_in = a[63] ^ b[63];
         ua_in  = ma;
         ub_in  = mb;
         acc_in = '0;
         rem_in = '0;
         ovf_in = 1'b0;
         unique case (op)
            OP_ADD: begin
               res_in = (a[63] == b[63] && sum[63] != a[63]) ? (a[63] ? SMIN : SMAX) : sum;
            end
            OP_SUB: begin
               res_in = (a[63] != b[63] && dif[63] != a[63]) ? (a[63] ? SMIN : SMAX) : dif;
            end
            OP_MUL: begin
               busy_in = 1'b1;
               cnt_in  = 7'd64;
            end
            OP_DIV: begin
               busy_in = 1'b1;
               cnt_in  = 7'd96;
            end
            default: res_in = '0;
         endcase
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            // one multiplier bit per cycle, msb first
            acc_in = {acc_ff[126:0], 1'b0} + (ua_ff[63] ? {64'd0, ub_ff} : 128'd0);
            ua_in  = {ua_ff[62:0], 1'b0};
         end else begin
            // dividend bits then 32 zero bits, msb first
            dbit = (cnt_ff > 7'd32) ? ua_ff[63] : 1'b0;
            if (cnt_ff > 7'd32) ua_in = {ua_ff[62:0], 1'b0};
            rsh  = {rem_ff[63:0], dbit};
            rsub = rsh - {1'b0, ub_ff};
            if (rsh >= {1'b0, ub_ff}) begin
               rem_in = rsub;
               if (cnt_ff > 7'd64) ovf_in = 1'b1;
               acc_in = {acc_ff[126:0], (cnt_ff <= 7'd64)};
            end else begin
               rem_in = rsh;
               acc_in = {acc_ff[126:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end else if (cnt_ff == 7'd0 && (op_ff == OP_MUL || op_ff == OP_DIV)) begin
         // finish: saturate and sign once after the last step
         if (op_ff == OP_MUL) res_in = signed_sat(acc_ff[95:32], neg_ff, acc_ff[127:96] != 0);
         else                 res_in = signed_sat(acc_ff[63:0], neg_ff, ovf_ff);
         op_in = OP_LPAREN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_LPAREN;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      neg_ff <= neg_in;
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      ovf_ff <= ovf_in;
      res_ff <= res_in;
   end

   // finishing cycle counts as busy
   assign busy   = busy_ff || (cnt_ff == 7'd0 && (op_ff == OP_MUL || op_ff == OP_DIV));
   assign result = res_ff;

endmodule

// ----- src/iee_datapath.sv -----
`timescale 1ns / 1ps
// datapath: value stack, operator stack, number accumulator, operand registers
// and the arithmetic unit; uses iee_pkg and iee_arith
module iee_datapath
   import iee_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status
);

   logic [63:0] vstack [VALUE_STACK_DEPTH];
   logic [2:0]  ostack [OPERATOR_STACK_DEPTH];
   logic [VAL_CNT_W-1:0] vcnt_ff, vcnt_in;
   logic [OP_CNT_W-1:0]  ocnt_ff, ocnt_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] a_ff, b_ff;
   logic [2:0]  aop_ff;
   logic [63:0] dig, lim, num10;
   logic        vwr, owr, arith_start, arith_busy;
   logic [63:0] vwdata;
   logic [63:0] arith_result;
   logic [VAL_PTR_W-1:0] vtop;
   logic [OP_PTR_W-1:0]  otop;

   assign vtop = VAL_PTR_W'(vcnt_ff - 1'b1);
   assign otop = OP_PTR_W'(ocnt_ff - 1'b1);

   // largest accumulator that can take one more digit without saturating
   always_comb begin
      unique case (cmd.digit)
         4'd0:    lim = SMAX / 64'd10;
         4'd1:    lim = (SMAX - (64'd1 << 32)) / 64'd10;
         4'd2:    lim = (SMAX - (64'd2 << 32)) / 64'd10;
         4'd3:    lim = (SMAX - (64'd3 << 32)) / 64'd10;
         4'd4:    lim = (SMAX - (64'd4 << 32)) / 64'd10;
         4'd5:    lim = (SMAX - (64'd5 << 32)) / 64'd10;
         4'd6:    lim = (SMAX - (64'd6 << 32)) / 64'd10;
         4'd7:    lim = (SMAX - (64'd7 << 32)) / 64'd10;
         4'd8:    lim = (SMAX - (64'd8 << 32)) / 64'd10;
         4'd9:    lim = (SMAX - (64'd9 << 32)) / 64'd10;
         default: lim = '0;
      endcase
   end

   always_comb begin
      dig   = {28'd0, cmd.digit, 32'd0};
      num10 = (num_ff << 3) + (num_ff << 1) + dig;
      vcnt_in = vcnt_ff;
      ocnt_in = ocnt_ff;
      num_in  = num_ff;
      vwr = 1'b0;
      owr = 1'b0;
      vwdata = num_ff;
      arith_start = 1'b0;
      unique case (cmd.op) inside
         CMD_DIGIT:    num_in = (num_ff > lim) ? SMAX : num10;
         CMD_PUSH_NUM: begin
            vwr = 1'b1; vcnt_in = vcnt_ff + 1'b1; num_in = '0;
         end
         CMD_PUSH_OP:  begin owr = 1'b1; ocnt_in = ocnt_ff + 1'b1; end
         CMD_POP_OP:   ocnt_in = ocnt_ff - 1'b1;
         CMD_LOAD_B, CMD_LOAD_A: vcnt_in = vcnt_ff - 1'b1;
         CMD_ARITH:    arith_start = 1'b1;
         CMD_PUSH_RES: begin
            vwr = 1'b1; vwdata = arith_result; vcnt_in = vcnt_ff + 1'b1;
         end
         CMD_CLEAR:    begin vcnt_in = '0; ocnt_in = '0; num_in = '0; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff <= '0;
         ocnt_ff <= '0;
         num_ff  <= '0;
      end else begin
         vcnt_ff <= vcnt_in;
         ocnt_ff <= ocnt_in;
         num_ff  <= num_in;
      end
      if (vwr) vstack[VAL_PTR_W'(vcnt_ff)] <= vwdata;
      if (owr) ostack[OP_PTR_W'(ocnt_ff)] <= cmd.arg;
      if (cmd.op == CMD_LOAD_B) b_ff <= vstack[vtop];
      if (cmd.op == CMD_LOAD_A) a_ff <= vstack[vtop];
      if (cmd.op == CMD_POP_OP) aop_ff <= ostack[otop];
   end

   iee_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (arith_start),
      .op     (aop_ff),
      .a      (a_ff),
      .b      (b_ff),
      .busy   (arith_busy),
      .result (arith_result)
   );

   always_comb begin
      status.value_count    = vcnt_ff;
      status.operator_count = ocnt_ff;
      status.top_op         = ostack[otop];
      status.busy           = arith_busy;
      status.b_zero         = (b_ff == 64'd0);
      status.top_value      = vstack[vtop];
   end

endmodule

// ----- src/iee_control.sv -----
`timescale 1ns / 1ps
// controller state machine: decodes characters and sequences reductions
// uses iee_pkg and the assertion macros
`include "infix_expression_evaluator_defines.svh"
module iee_control
   import iee_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    in_char,
   input  logic          in_last,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [63:0]   out_value,
   output logic [2:0]    out_status
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHAR   = 4'd1;
   localparam logic [3:0] S_REDUCE = 4'd2;  // decide whether to apply top op
   localparam logic [3:0] S_LOADB  = 4'd3;
   localparam logic [3:0] S_LOADA  = 4'd4;
   localparam logic [3:0] S_START  = 4'd5;
   localparam logic [3:0] S_WAIT   = 4'd6;
   localparam logic [3:0] S_PUSHR  = 4'd7;
   localparam logic [3:0] S_FINAL  = 4'd8;  // end of expression
   localparam logic [3:0] S_EMIT   = 4'd9;
   localparam logic [3:0] S_POPOP  = 4'd10;

   // reduction reasons
   localparam logic [1:0] M_OPER  = 2'd0;
   localparam logic [1:0] M_CLOSE = 2'd1;
   localparam logic [1:0] M_END   = 2'd2;

   logic [3:0]  state_ff, state_in;
   logic [7:0]  ch_ff, ch_in;
   logic        last_ff, last_in;
   logic        innum_ff, innum_in;
   logic [2:0]  err_ff, err_in;
   logic [1:0]  mode_ff, mode_in;
   logic [2:0]  newop_ff, newop_in;
   logic        ovalid_ff, ovalid_in;
   logic [63:0] oval_ff, oval_in;
   logic [2:0]  ost_ff, ost_in;
   logic        is_digit, is_space, is_op;
   logic [2:0]  ch_op;

   // the op popped for the current reduction is a divide
   logic divop_pending;
   logic [2:0] popped_ff;
   assign divop_pending = (popped_ff == OP_DIV);

   always_comb begin
      is_digit = ch_ff >= CH_ZERO && ch_ff <= CH_NINE;
      is_space = ch_ff == CH_SPACE || (ch_ff >= CH_TAB && ch_ff <= CH_CR);
      is_op    = ch_ff == CH_PLUS || ch_ff == CH_MINUS || ch_ff == CH_STAR ||
                 ch_ff == CH_SLASH;
      ch_op    = (ch_ff == CH_PLUS) ? OP_ADD : (ch_ff == CH_MINUS) ? OP_SUB :
                 (ch_ff == CH_STAR) ? OP_MUL : OP_DIV;
   end

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      last_in  = last_ff;
      innum_in = innum_ff;
      err_in   = err_ff;
      mode_in  = mode_ff;
      newop_in = newop_ff;
      ovalid_in = ovalid_ff && !out_ready;
      oval_in  = oval_ff;
      ost_in   = ost_ff;
      cmd      = '0;
      cmd.op   = CMD_NONE;
      cmd.digit = 4'(ch_ff - CH_ZERO);
      in_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               ch_in = in_char;
               last_in = in_last;
               state_in = (err_ff != ST_OK) ? (in_last ? S_FINAL : S_IDLE) : S_CHAR;
            end
         end
         S_CHAR: begin
            if (innum_ff && !is_digit) begin
               // number ends: push it, then handle this char again (overflow if the stack is full)
               innum_in = 1'b0;
               if (status.value_count >= VAL_CNT_W'(VALUE_STACK_DEPTH)) begin
                  err_in = ST_OVERFLOW;
                  state_in = last_ff ? S_FINAL : S_IDLE;
               end else begin
                  cmd.op = CMD_PUSH_NUM;
               end
            end else if (is_space) begin
               state_in = last_ff ? S_FINAL : S_IDLE;
            end else if (is_digit) begin
               cmd.op = CMD_DIGIT;
               innum_in = 1'b1;
               state_in = last_ff ? S_FINAL : S_IDLE;
            end else if (ch_ff == CH_LPAREN) begin
               if (status.operator_count >= OP_CNT_W'(OPERATOR_STACK_DEPTH))
                  err_in = ST_OVERFLOW;
               else begin
                  cmd.op = CMD_PUSH_OP;
                  cmd.arg = OP_LPAREN;
               end
               state_in = last_ff ? S_FINAL : S_IDLE;
            end else if (ch_ff == CH_RPAREN) begin
               mode_in = M_CLOSE;
               state_in = S_REDUCE;
            end else if (is_op) begin
               mode_in = M_OPER;
               newop_in = ch_op;
               state_in = S_REDUCE;
            end else begin
               err_in = ST_BADCHAR;
               state_in = last_ff ? S_FINAL : S_IDLE;
            end
         end
         S_REDUCE: begin
            if (err_ff != ST_OK) begin
               state_in = (mode_ff == M_END || last_ff) ? S_EMIT : S_IDLE;
               if (mode_ff != M_END && last_ff) state_in = S_FINAL;
            end else if (status.operator_count == '0) begin
               unique case (mode_ff)
                  M_CLOSE: begin
                     err_in = ST_PAREN;
                     state_in = last_ff ? S_FINAL : S_IDLE;
                  end
                  M_OPER: begin
                     cmd.op = CMD_PUSH_OP;
                     cmd.arg = newop_ff;
                     state_in = last_ff ? S_FINAL : S_IDLE;
                  end
                  default: begin
                     if (status.value_count == '0) err_in = ST_EMPTY;
                     else cmd.op = CMD_READ_TOP;
                     state_in = S_EMIT;
                  end
               endcase
            end else if (mode_ff == M_CLOSE && status.top_op == OP_LPAREN) begin
               cmd.op = CMD_POP_OP;
               state_in = last_ff ? S_FINAL : S_IDLE;
            end else if (mode_ff == M_END && status.top_op == OP_LPAREN) begin
               err_in = ST_PAREN;
               state_in = S_EMIT;
            end else if (mode_ff == M_OPER && prio(status.top_op) < prio(newop_ff)) begin
               if (status.operator_count >= OP_CNT_W'(OPERATOR_STACK_DEPTH))
                  err_in = ST_OVERFLOW;
               else begin
                  cmd.op = CMD_PUSH_OP;
                  cmd.arg = newop_ff;
               end
               state_in = last_ff ? S_FINAL : S_IDLE;
            end else begin
               cmd.op = CMD_POP_OP;
               state_in = S_POPOP;
            end
         end
         S_POPOP: begin
            if (status.value_count < VAL_CNT_W'(2)) begin
               err_in = ST_UNDERFLOW;
               state_in = S_REDUCE;
            end else begin
               cmd.op = CMD_LOAD_B;
               state_in = S_LOADA;
            end
         end
         S_LOADA: begin
            cmd.op = CMD_LOAD_A;
            state_in = S_START;
         end
         S_START: begin
            if (status.b_zero && divop_pending) begin
               err_in = ST_DIVZERO;
               state_in = S_REDUCE;
            end else begin
               cmd.op = CMD_ARITH;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!status.busy) state_in = S_PUSHR;
         end
         S_PUSHR: begin
            cmd.op = CMD_PUSH_RES;
            state_in = S_REDUCE;
         end
         S_FINAL: begin
            mode_in = M_END;
            if (err_ff == ST_OK && innum_ff) begin
               innum_in = 1'b0;
               if (status.value_count >= VAL_CNT_W'(VALUE_STACK_DEPTH))
                  err_in = ST_OVERFLOW;
               else cmd.op = CMD_PUSH_NUM;
            end
            state_in = (err_ff == ST_OK) ? S_REDUCE : S_EMIT;
         end
         S_EMIT: begin
            if (!ovalid_ff || out_ready) begin
               ovalid_in = 1'b1;
               oval_in  = (err_ff == ST_OK) ? status.top_value : 64'd0;
               ost_in   = err_ff;
               err_in   = ST_OK;
               innum_in = 1'b0;
               cmd.op   = CMD_CLEAR;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         innum_ff  <= 1'b0;
         err_ff    <= ST_OK;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         innum_ff  <= innum_in;
         err_ff    <= err_in;
         ovalid_ff <= ovalid_in;
      end
      ch_ff    <= ch_in;
      last_ff  <= last_in;
      mode_ff  <= mode_in;
      newop_ff <= newop_in;
      oval_ff  <= oval_in;
      ost_ff   <= ost_in;
      if (cmd.op == CMD_POP_OP) popped_ff <= status.top_op;
   end

   assign out_valid  = ovalid_ff;
   assign out_value  = oval_ff;
   assign out_status = ost_ff;

   `IEE_ASSERT(a_ok_no_value_err, clock, reset,
      (out_valid && out_status != ST_OK) |-> (out_value == 64'd0),
      "error result carries nonzero value")
   `IEE_ASSERT(a_ready_idle, clock, reset,
      in_ready |-> (state_ff == S_IDLE), "ready outside idle")
   `IEE_ASSERT(a_arith_wait, clock, reset,
      (state_ff == S_WAIT && status.busy) |=> (state_ff == S_WAIT),
      "left wait while arithmetic busy")
   `IEE_ASSERT(a_emit_clears, clock, reset,
      (state_ff == S_EMIT && state_in == S_IDLE) |=> (err_ff == ST_OK && out_valid),
      "emit did not clear error")

endmodule

// ----- src/infix_expression_evaluator.sv -----
`timescale 1ns / 1ps
// top level of the infix expression evaluator
// depends on iee_pkg, iee_control, iee_datapath and the assertion macros
//
// usage:
//  - req channel: one ascii character per transfer in req_tdata, req_tlast
//    marks the last character of an expression
//  - rsp channel: one transfer per expression, after the last character;
//    rsp_tdata holds the q31.32 value and the 3-bit status
//  - a character that ends a number is pushed first; every operator
//    applied runs in the shared arithmetic unit, multiply at one product
//    bit per cycle and divide at one quotient bit per cycle
//  - the end of an expression applies the remaining operators, then the
//    result goes to a one-entry output register
//  - the block takes one character at a time; req_tready is low while a
//    character or the end of an expression is being processed
//  - a stalled rsp side holds the result; the next expression may start
//    and only waits at its own end if the old result is still untaken
//  - reset (synchronous) empties both stacks and clears the error state;
//    no clearing pass is needed, the stacks are tracked by counts only
`include "infix_expression_evaluator_defines.svh"
module infix_expression_evaluator
   import iee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,   // end_of_expression
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [63:0] result_value, [66:64] status, rest zero
);

   dp_cmd_type    cmd;
   dp_status_type dp_status;
   logic [63:0]   rsp_value;
   logic [2:0]    rsp_status;

   iee_control u_control (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_char      (req_tdata),
      .in_last      (req_tlast),
      .status       (dp_status),
      .cmd          (cmd),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_value    (rsp_value),
      .out_status   (rsp_status)
   );

   iee_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (dp_status)
   );

   assign rsp_tdata = {5'd0, rsp_status, rsp_value};

   `IEE_ASSERT(a_rsp_status_range, clock, reset,
      rsp_tvalid |-> (rsp_tdata[66:64] != 3'd7), "status code out of range")
   `IEE_ASSERT_ALWAYS(a_rsp_pad_zero, clock,
      rsp_tdata[71:67] == 5'd0, "padding bits not zero")

endmodule

// ----- dv/iee_scoreboard.sv -----
`timescale 1ns / 1ps
// expression evaluation predictor and result checker for the infix expression evaluator
// depends on iee_pkg; watches the req and rsp channels of the block
module iee_scoreboard
   import iee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] value;
   } expr_result_type;

   expr_result_type expected_results[$];
   logic [63:0]   vals[VALUE_STACK_DEPTH];
   logic [2:0]    ops[OPERATOR_STACK_DEPTH];
   int unsigned   n_vals, n_ops;
   logic [63:0]   acc;
   logic          digits_open;
   logic [2:0]    err;

   function automatic logic [1:0] rank(input logic [2:0] op);
      if (op == OP_ADD || op == OP_SUB) return 2'd1;
      if (op == OP_MUL || op == OP_DIV) return 2'd2;
      return 2'd0;
   endfunction

   function automatic logic [63:0] clamp(input logic [63:0] mag, input logic neg,
                                         input logic ovf);
      if (neg) return (ovf || mag > SMIN) ? SMIN : (64'd0 - mag);
      return (ovf || mag > SMAX) ? SMAX : mag;
   endfunction

   function automatic logic [63:0] fx_op(input logic [2:0] op, input logic [63:0] a,
                                         input logic [63:0] b);
      logic [63:0]  r, ua, ub;
      logic [127:0] p, q;
      logic         neg;
      neg = a[63] ^ b[63];
      ua  = a[63] ? -a : a;
      ub  = b[63] ? -b : b;
      case (op)
         OP_ADD: begin
            r = a + b;
            if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? SMIN : SMAX;
         end
         OP_SUB: begin
            r = a - b;
            if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? SMIN : SMAX;
         end
         OP_MUL: begin
            p = {64'd0, ua} * {64'd0, ub};
            r = clamp(p[95:32], neg, p[127:96] != 0);
         end
         default: begin
            q = {32'd0, ua, 32'd0} / {64'd0, ub};
            r = clamp(q[63:0], neg, q[127:64] != 0);
         end
      endcase
      return r;
   endfunction

   task automatic reduce_top();
      logic [2:0] op;
      logic [63:0] a, b;
      op = ops[n_ops - 1];
      n_ops--;
      if (n_vals < 2) begin
         err = ST_UNDERFLOW;
         return;
      end
      b = vals[n_vals - 1];
      a = vals[n_vals - 2];
      n_vals -= 2;
      if (op == OP_DIV && b == 0) begin
         err = ST_DIVZERO;
         return;
      end
      vals[n_vals] = fx_op(op, a, b);
      n_vals++;
   endtask

   task automatic push_val(input logic [63:0] v);
      if (n_vals >= VALUE_STACK_DEPTH) err = ST_OVERFLOW;
      else begin
         vals[n_vals] = v;
         n_vals++;
      end
   endtask

   task automatic push_operator(input logic [2:0] op);
      if (n_ops >= OPERATOR_STACK_DEPTH) err = ST_OVERFLOW;
      else begin
         ops[n_ops] = op;
         n_ops++;
      end
   endtask

   task automatic take_char(input logic [7:0] c);
      logic        is_digit;
      logic [2:0]  op;
      logic [63:0] d;
      is_digit = (c >= CH_ZERO && c <= CH_NINE);
      if (digits_open && !is_digit) begin
         digits_open = 1'b0;
         push_val(acc);
         acc = '0;
         if (err != ST_OK) return;
      end
      if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) return;
      if (is_digit) begin
         d = {28'd0, c[3:0], 32'd0};
         if (acc > (SMAX - d) / 10) acc = SMAX;
         else acc = acc * 10 + d;
         digits_open = 1'b1;
      end else if (c == CH_LPAREN) begin
         push_operator(OP_LPAREN);
      end else if (c == CH_RPAREN) begin
         while (err == ST_OK && n_ops > 0 && ops[n_ops - 1] != OP_LPAREN) reduce_top();
         if (err != ST_OK) return;
         if (n_ops > 0) n_ops--;
         else err = ST_PAREN;
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
         op = (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB :
              (c == CH_STAR) ? OP_MUL : OP_DIV;
         while (err == ST_OK && n_ops > 0 && rank(ops[n_ops - 1]) >= rank(op))
            reduce_top();
         if (err == ST_OK) push_operator(op);
      end else begin
         err = ST_BADCHAR;
      end
   endtask

   task automatic finish_expression();
      expr_result_type res;
      res.value = '0;
      if (err == ST_OK && digits_open) push_val(acc);
      while (err == ST_OK && n_ops > 0) begin
         if (ops[n_ops - 1] == OP_LPAREN) err = ST_PAREN;
         else reduce_top();
      end
      if (err == ST_OK) begin
         if (n_vals == 0) err = ST_EMPTY;
         else res.value = vals[n_vals - 1];
      end
      res.status = err;
      if (err != ST_OK) res.value = '0;
      expected_results.push_back(res);
      n_vals = 0;
      n_ops = 0;
      acc = '0;
      digits_open = 1'b0;
      err = ST_OK;
   endtask

   initial begin
      error_count = 0;
      pending_count = 0;
      n_vals = 0;
      n_ops = 0;
      acc = '0;
      digits_open = 1'b0;
      err = ST_OK;
   end

   always @(posedge clock) begin
      expr_result_type exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result transfer: value %h status %0d",
                           rsp_tdata[63:0], rsp_tdata[66:64]);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_tdata[63:0] !== exp_r.value || rsp_tdata[66:64] !== exp_r.status
                   || rsp_tdata[71:67] !== 5'd0) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("result mismatch: expected value %h status %0d, got %h status %0d",
                              exp_r.value, exp_r.status, rsp_tdata[63:0], rsp_tdata[66:64]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (err == ST_OK) take_char(req_tdata);
            if (req_tlast) finish_expression();
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ----- dv/infix_expression_evaluator_tb.sv -----
`timescale 1ns / 1ps
// stimulus and verdict for the infix expression evaluator
// depends on iee_pkg, infix_expression_evaluator and iee_scoreboard
module infix_expression_evaluator_tb;
   import iee_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] character
   logic        req_tlast;    // end_of_expression
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // [63:0] result_value, [66:64] status
   int          error_count;
   int          pending_count;
   int          cycle_count;
   int          sent_chars;
   logic        calm;         // no idling on either side while set

   localparam int CYCLE_LIMIT = 2_000_000;

   infix_expression_evaluator DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   iee_scoreboard checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver stalls with a chance of about 7 in 100 unless in the calm stretch
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(99) >= 7);
   end

   // one character transfer, with random idle cycles in front
   task automatic send_char(input logic [7:0] c, input logic last);
      while (!calm && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent_chars++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // well-formed expression with random numbers, operators and parentheses
   task automatic send_random_expression();
      int depth, terms, k;
      byte ops_set[4];
      depth = 0;
      ops_set = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
      terms = $urandom_range(1, 6);
      for (int t = 0; t < terms; t++) begin
         if (depth < 3 && $urandom_range(3) == 0) begin
            send_char(CH_LPAREN, 1'b0);
            depth++;
         end
         k = ($urandom_range(9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 3);
         for (int d = 0; d < k; d++) send_char(8'(CH_ZERO + $urandom_range(9)), 1'b0);
         if ($urandom_range(4) == 0) send_char(CH_SPACE, 1'b0);
         if (depth > 0 && $urandom_range(2) == 0) begin
            send_char(CH_RPAREN, 1'b0);
            depth--;
         end
         if (t != terms - 1) send_char(ops_set[$urandom_range(3)], 1'b0);
      end
      while (depth > 0) begin
         send_char(CH_RPAREN, 1'b0);
         depth--;
      end
      // the flagged character: space, digit or line feed
      case ($urandom_range(2))
         0: send_char(CH_SPACE, 1'b1);
         1: send_char(8'(CH_ZERO + $urandom_range(9)), 1'b1);
         default: send_char(8'h0A, 1'b1);
      endcase
   endtask

   // broken sequences and arbitrary bytes
   task automatic send_noise_expression();
      int n;
      byte pool[12];
      pool = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN,
               CH_ZERO, 8'h31, 8'h37, CH_SPACE, CH_TAB, CH_CR};
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)), i == n - 1);
         else send_char(pool[$urandom_range(11)], i == n - 1);
      end
   endtask

   initial begin
      cycle_count = 0;
      sent_chars  = 0;
      calm        = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every operator, precedence, grouping and each error kind
      send_text("1+2*3");
      send_text("(7-9)/2");
      send_text("8/0");
      send_text("(1+2");
      send_text("1+2)");
      send_text(" ");
      send_text("-5");
      send_text("1 2");
      send_text("3#4");
      send_char(8'hFF, 1'b1);
      send_text("9999999999999*99999");
      send_text("0-9999999999/1*3");
      send_text("((((((((((((((((((1");
      send_text("1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1");
      send_text("1*(2*(3*(4*(5*(6*(7*(8*(9*(1*(2*(3*(4*(5*(6*(7*(8))))))))))))))))");
      send_text("\t5\r");

      // random: mostly well-formed, some noise; a calm stretch in the middle
      while (sent_chars < 1840) begin
         calm = (sent_chars > 800 && sent_chars < 1100);
         if ($urandom_range(9) < 8) send_random_expression();
         else send_noise_expression();
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- infix_expression_evaluator.f -----
+incdir+src
src/iee_pkg.sv
src/iee_arith.sv
src/iee_datapath.sv
src/iee_control.sv
src/infix_expression_evaluator.sv
dv/iee_scoreboard.sv
dv/infix_expression_evaluator_tb.sv
